// ===== rtl/psrc_pkg.sv =====
package psrc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W = 24;
    localparam int DEF_MAX_RATIO = 32;
    localparam int DEF_FRAC_BITS = 24;
    localparam logic [1:0] MODE_COPY = 2'd0;
    localparam logic [1:0] MODE_UP = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_STEP = 1'b1;

    typedef struct packed {
        logic load;
        logic interp;
        logic interp_self;
        logic box_add;
        logic div_start;
        logic emit_copy;
        logic emit_interp;
        logic emit_div;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic phase_lt_one;
        logic box_full;
        logic box_nonzero;
        logic div_done;
    } stat_t;

endpackage

// ===== rtl/psrc_datapath.sv =====
module psrc_datapath #(
    parameter int MAX_RATIO = psrc_pkg::DEF_MAX_RATIO,
    parameter int FRAC_BITS = psrc_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psrc_pkg::cmd_t        cmd,
    output psrc_pkg::stat_t       stat,
    input  logic [1:0]            mode_cfg,
    input  logic [23:0]           step_cfg,
    input  logic signed [15:0]    in_sample,
    output logic signed [15:0]    res_sample
);
    localparam int CNT_W = $clog2(MAX_RATIO + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int PH_W = FRAC_BITS + 1;
    localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0] LO = PH_W'((64'd1 << FRAC_BITS) / MAX_RATIO);

    logic signed [15:0] prev_reg, cur_reg, res_reg;
    logic [PH_W-1:0] phase_reg, phase_next, step_eff;
    logic have_prev_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [16+FRAC_BITS+1:0] prod_a, prod_b;
    logic signed [16+FRAC_BITS+2:0] prod_sum;
    logic signed [15:0] interp_val;
    logic [SUM_W-1:0] div_rem_reg, div_q_reg, mag;
    logic [$clog2(SUM_W+1)-1:0] div_i_reg;
    logic div_neg_reg, div_busy_reg;
    logic [CNT_W:0] trial_rem;
    logic [SUM_W-1:0] rem_sh;
    logic signed [15:0] a_s, b_s;
    logic [FRAC_BITS:0] f;
    logic [PH_W-1:0] step_raw;

    assign step_raw = PH_W'(step_cfg[23:0]);
    always_comb
    begin
        step_eff = step_raw;
        if (step_raw < LO) step_eff = LO;
        if (step_raw > ONE - 1'b1) step_eff = ONE - 1'b1;
    end

    assign a_s = cmd.interp_self ? cur_reg : prev_reg;
    assign b_s = cur_reg;
    assign f = phase_reg[FRAC_BITS:0];
    assign prod_a = a_s * $signed({1'b0, ONE[FRAC_BITS:0] - f});
    assign prod_b = b_s * $signed({1'b0, f});
    assign prod_sum = prod_a + prod_b;
    assign interp_val = 16'((prod_sum < 0) ?
        -((-prod_sum) >>> FRAC_BITS) : (prod_sum >>> FRAC_BITS));

    assign mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_sh = {div_rem_reg[SUM_W-2:0], div_q_reg[SUM_W-1]};
    assign trial_rem = (CNT_W+1)'(rem_sh) - {1'b0, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            cur_reg <= '0;
            have_prev_reg <= 1'b0;
            phase_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            div_busy_reg <= 1'b0;
            div_i_reg <= '0;
            div_rem_reg <= '0;
            div_q_reg <= '0;
            div_neg_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                cur_reg <= in_sample;
            if (cmd.interp)
            begin
                res_reg <= interp_val;
                phase_reg <= phase_reg + step_eff;
            end
            if (cmd.emit_interp)
                phase_reg <= phase_reg - ONE;
            if (cmd.emit_copy)
            begin
                if (mode_cfg == psrc_pkg::MODE_UP)
                begin
                    prev_reg <= cur_reg;
                    have_prev_reg <= 1'b1;
                end
                else
                    res_reg <= cur_reg;
            end
            if (cmd.box_add)
            begin
                sum_reg <= sum_reg + SUM_W'(cur_reg);
                cnt_reg <= cnt_reg + 1'b1;
                phase_reg <= phase_reg + step_eff;
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_i_reg <= '0;
                div_rem_reg <= '0;
                div_q_reg <= mag;
                div_neg_reg <= sum_reg[SUM_W-1];
            end
            else if (div_busy_reg)
            begin
                if (trial_rem[CNT_W] && rem_sh[SUM_W-1:CNT_W] == '0)
                begin
                    div_rem_reg <= rem_sh;
                    div_q_reg <= {div_q_reg[SUM_W-2:0], 1'b0};
                end
                else
                begin
                    div_rem_reg <= SUM_W'(rem_sh - SUM_W'(cnt_reg));
                    div_q_reg <= {div_q_reg[SUM_W-2:0], 1'b1};
                end
                div_i_reg <= div_i_reg + 1'b1;
                if (div_i_reg == ($clog2(SUM_W+1))'(SUM_W - 1))
                    div_busy_reg <= 1'b0;
            end
            if (cmd.emit_div)
            begin
                res_reg <= div_neg_reg ? 16'(-div_q_reg) : 16'(div_q_reg);
                sum_reg <= '0;
                cnt_reg <= '0;
                if (!phase_reg[FRAC_BITS] == 1'b0)
                    phase_reg <= phase_reg - ONE;
            end
            if (cmd.clear)
            begin
                prev_reg <= '0;
                have_prev_reg <= 1'b0;
                phase_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    assign stat.have_prev = have_prev_reg;
    assign stat.phase_lt_one = phase_reg < ONE;
    assign stat.box_full = phase_reg >= ONE;
    assign stat.box_nonzero = cnt_reg != '0;
    assign stat.div_done = !div_busy_reg && !cmd.div_start;
    assign res_sample = res_reg;

`ifndef SYNTH
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_div |-> !div_busy_reg) else $error("result taken from busy divider");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg) else $error("divider did not start");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> !have_prev_reg && cnt_reg == '0) else $error("clear failed");
`endif

endmodule

// ===== rtl/psrc_ctrl.sv =====
module psrc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      mode_cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_last,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_last,
    output psrc_pkg::cmd_t  cmd,
    input  psrc_pkg::stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_UP_CHK, S_UP_OUT, S_UP_SELF_CHK, S_UP_SELF_OUT,
        S_DN_CHK, S_DIV, S_DN_OUT, S_FLUSH_CHK, S_COPY_OUT, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic last_reg, last_next;
    logic flushed_reg, flushed_next;
    logic ovalid_reg, ovalid_next;
    logic olast_reg, olast_next;
    logic free;

    assign free = !ovalid_reg || out_ready;
    assign in_ready = state_reg == S_IDLE;
    assign out_valid = ovalid_reg;
    assign out_last = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        flushed_next = flushed_reg;
        ovalid_next = ovalid_reg && !out_ready;
        olast_next = olast_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    last_next = in_last;
                    flushed_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (mode_cfg == psrc_pkg::MODE_UP)
                begin
                    if (stat.have_prev)
                        state_next = S_UP_CHK;
                    else
                    begin
                        cmd.emit_copy = 1'b1;
                        state_next = last_reg ? S_UP_SELF_CHK : S_FINISH;
                    end
                end
                else if (mode_cfg == psrc_pkg::MODE_DOWN)
                begin
                    cmd.box_add = 1'b1;
                    state_next = S_DN_CHK;
                end
                else
                    state_next = S_COPY_OUT;
            end
            S_UP_CHK, S_UP_SELF_CHK:
            begin
                if (stat.phase_lt_one)
                begin
                    if (free)
                    begin
                        cmd.interp = 1'b1;
                        cmd.interp_self = state_reg == S_UP_SELF_CHK;
                        state_next = state_reg == S_UP_CHK ? S_UP_OUT : S_UP_SELF_OUT;
                    end
                end
                else
                begin
                    cmd.emit_interp = 1'b1;
                    if (state_reg == S_UP_CHK)
                    begin
                        cmd.emit_copy = 1'b1;
                        state_next = last_reg ? S_UP_SELF_CHK : S_FINISH;
                    end
                    else
                        state_next = S_FINISH;
                end
            end
            S_UP_OUT, S_UP_SELF_OUT:
            begin
                ovalid_next = 1'b1;
                olast_next = last_reg && state_reg == S_UP_SELF_OUT && !stat.phase_lt_one;
                state_next = state_reg == S_UP_OUT ? S_UP_CHK : S_UP_SELF_CHK;
            end
            S_DN_CHK:
            begin
                if (stat.box_full || (last_reg && stat.box_nonzero && !flushed_reg))
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (stat.div_done && free)
                begin
                    cmd.emit_div = 1'b1;
                    state_next = S_DN_OUT;
                end
            end
            S_DN_OUT:
            begin
                ovalid_next = 1'b1;
                olast_next = last_reg;
                state_next = S_DN_CHK;
            end
            S_COPY_OUT:
            begin
                if (free)
                begin
                    cmd.emit_copy = 1'b1;
                    state_next = S_FLUSH_CHK;
                end
            end
            S_FLUSH_CHK:
            begin
                ovalid_next = 1'b1;
                olast_next = last_reg;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (last_reg)
                    cmd.clear = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg <= 1'b0;
            flushed_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            flushed_reg <= flushed_next;
            ovalid_reg <= ovalid_next;
            olast_reg <= olast_next;
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.interp && !cmd.emit_div) else $error("work while idle");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_div |-> free) else $error("overwrite of pending result");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISPATCH) else $error("bad accept");
`endif

endmodule

// ===== rtl/pcm_sample_rate_converter.sv =====
// Streaming resampler for signed 16-bit mono PCM, with copy, linear-interpolation upsampling
// and box-average downsampling modes; one input is taken at a time, and each result sits in
// an output register, so the block waits for the output only while that register is still
// full; a downsampled input that yields a result also waits for the bit-serial divider that
// forms the box average.
module pcm_sample_rate_converter #(
    parameter int MAX_RATIO = psrc_pkg::DEF_MAX_RATIO,
    parameter int FRAC_BITS = psrc_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] in_sample,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample,
    output logic               out_last
);
    logic [1:0] mode_reg;
    logic [23:0] step_reg;
    psrc_pkg::cmd_t cmd;
    psrc_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= psrc_pkg::MODE_COPY;
            step_reg <= 24'd8388608;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psrc_pkg::CFG_MODE: mode_reg <= cfg_data[1:0];
                psrc_pkg::CFG_STEP: step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    psrc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .mode_cfg(mode_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_last(in_last),
        .out_valid(out_valid), .out_ready(out_ready), .out_last(out_last),
        .cmd(cmd), .stat(stat)
    );

    psrc_datapath #(.MAX_RATIO(MAX_RATIO), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .mode_cfg(mode_reg), .step_cfg(step_reg),
        .in_sample(in_sample), .res_sample(out_sample)
    );

`ifndef SYNTH
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == psrc_pkg::CFG_MODE |=> mode_reg == $past(cfg_data[1:0]))
        else $error("mode write lost");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("double accept");
`endif

endmodule
